// ===== rtl/assert_macros.svh =====
// assertion macros for the port-level checker of the distance unit
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, switched off while reset is asserted
`define PCD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("distance unit assertion failed");

// concurrent assertion that also holds during reset
`define PCD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("distance unit assertion failed");

`endif

// ===== rtl/pcd_pkg.sv =====
// shared types and constants of the planar city distance unit
// no dependencies
package pcd_pkg;

  // coordinate fields and the part of them that is used
  localparam int InBits    = 16;
  localparam int CoordBits = 16;
  localparam int EffBits   = (CoordBits < InBits) ? CoordBits : InBits;

  // squared distance and root widths
  localparam int D2Bits   = 2 * EffBits + 1;
  localparam int RootBits = EffBits + 1;
  localparam int SubBits  = 2 * RootBits + 4;

  // result field
  localparam int DistBits = 17;
  localparam int DistMax  = (1 << DistBits) - 1;

  // queue between front and back
  localparam int QueueDepth   = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);

  // distance modes
  localparam logic MODE_EUC = 1'b0;
  localparam logic MODE_ATT = 1'b1;

  // one classified job on its way from front to back
  typedef struct packed {
    logic              mode;
    logic [D2Bits-1:0] d2;
  } job_t;

endpackage

// ===== rtl/pcd_ifs.sv =====
// valid/ready channel interfaces of the distance unit
// depends on pcd_pkg
interface pcd_in_if;
  import pcd_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [InBits-1:0] x_a;
  logic [InBits-1:0] y_a;
  logic [InBits-1:0] x_b;
  logic [InBits-1:0] y_b;

  modport source (output valid, mode, x_a, y_a, x_b, y_b, input ready);
  modport sink   (input valid, mode, x_a, y_a, x_b, y_b, output ready);
endinterface

interface pcd_out_if;
  import pcd_pkg::*;

  logic                valid;
  logic                ready;
  logic [DistBits-1:0] distance;

  modport source (output valid, distance, input ready);
  modport sink   (input valid, distance, output ready);
endinterface

// ===== rtl/pcd_front.sv =====
// front part: takes coordinate pairs, forms dx, dy, their squares and d2
// depends on pcd_pkg and pcd_ifs
module pcd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcd_in_if.sink        req_i,
  output pcd_pkg::job_t job_o,
  output logic          job_valid_o,
  input  logic          job_ready_i
);
  import pcd_pkg::*;

  // elastic three-stage pipe: difference, square, sum
  logic [2:0] v_q;
  logic [2:0] rdy;

  logic [EffBits-1:0]   dx_q, dy_q, dx_d, dy_d;
  logic [2*EffBits-1:0] sqx_q, sqy_q;
  logic [D2Bits-1:0]    d2_q;
  logic [2:0]           mode_q;
  logic [EffBits-1:0]   xa, ya, xb, yb;

  assign rdy[2] = !v_q[2] || job_ready_i;
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];

  assign req_i.ready = rdy[0];

  assign xa = req_i.x_a[EffBits-1:0];
  assign ya = req_i.y_a[EffBits-1:0];
  assign xb = req_i.x_b[EffBits-1:0];
  assign yb = req_i.y_b[EffBits-1:0];

  always_comb begin
    dx_d = (xa >= xb) ? (xa - xb) : (xb - xa);
    dy_d = (ya >= yb) ? (ya - yb) : (yb - ya);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= req_i.valid;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && req_i.valid) begin
      dx_q      <= dx_d;
      dy_q      <= dy_d;
      mode_q[0] <= req_i.mode;
    end
    if (rdy[1] && v_q[0]) begin
      sqx_q     <= (2*EffBits)'(dx_q) * (2*EffBits)'(dx_q);
      sqy_q     <= (2*EffBits)'(dy_q) * (2*EffBits)'(dy_q);
      mode_q[1] <= mode_q[0];
    end
    if (rdy[2] && v_q[1]) begin
      d2_q      <= D2Bits'(sqx_q) + D2Bits'(sqy_q);
      mode_q[2] <= mode_q[1];
    end
  end

  assign job_valid_o = v_q[2];
  assign job_o.mode  = mode_q[2];
  assign job_o.d2    = d2_q;

endmodule

// ===== rtl/pcd_fifo.sv =====
// short register queue that decouples front and back
// depends on pcd_pkg
module pcd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcd_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  output pcd_pkg::job_t job_o,
  output logic          job_valid_o,
  input  logic          job_ready_i
);
  import pcd_pkg::*;

  job_t                  mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrBits:0]   cnt_q;
  logic                    push, pop;

  assign job_ready_o = (cnt_q != (QueuePtrBits+1)'(QueueDepth));
  assign job_valid_o = (cnt_q != '0);
  assign push        = job_valid_i && job_ready_o;
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

// ===== rtl/pcd_back.sv =====
// back part: pipelined bit-per-stage square root, rounding and output register
// depends on pcd_pkg and pcd_ifs
module pcd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcd_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  pcd_out_if.source     rsp_o
);
  import pcd_pkg::*;

  // stage s settles root bit RootBits-1-s
  logic                v_q    [RootBits];
  logic                mode_q [RootBits];
  logic [D2Bits-1:0]   rem_q  [RootBits];
  logic [RootBits-1:0] root_q [RootBits];

  logic                in_v    [RootBits];
  logic                in_mode [RootBits];
  logic [D2Bits-1:0]   in_rem  [RootBits];
  logic [RootBits-1:0] in_root [RootBits];

  logic [RootBits:0]   rdy;

  logic                out_v_q;
  logic [DistBits-1:0] out_dist_q;

  assign in_v[0]    = job_valid_i;
  assign in_mode[0] = job_i.mode;
  assign in_rem[0]  = job_i.d2;
  assign in_root[0] = '0;
  assign job_ready_o = rdy[0];

  assign rdy[RootBits] = !out_v_q || rsp_o.ready;

  for (genvar s = 0; s < RootBits; s++) begin : g_stage
    localparam int Bit = RootBits - 1 - s;

    logic [SubBits-1:0]  trial, sub;
    logic                take;
    logic [D2Bits-1:0]   rem_d;
    logic [RootBits-1:0] root_d;

    if (s > 0) begin : g_link
      assign in_v[s]    = v_q[s-1];
      assign in_mode[s] = mode_q[s-1];
      assign in_rem[s]  = rem_q[s-1];
      assign in_root[s] = root_q[s-1];
    end

    assign rdy[s] = !v_q[s] || rdy[s+1];

    // growth of k*root^2 when this bit is set, k = 1 or 10
    always_comb begin
      trial  = (SubBits'(in_root[s]) << (Bit + 1)) | (SubBits'(1) << (2 * Bit));
      sub    = (in_mode[s] == MODE_ATT) ? ((trial << 3) + (trial << 1)) : trial;
      take   = (SubBits'(in_rem[s]) >= sub);
      rem_d  = take ? D2Bits'(SubBits'(in_rem[s]) - sub) : in_rem[s];
      root_d = take ? (in_root[s] | (RootBits'(1) << Bit)) : in_root[s];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= in_v[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && in_v[s]) begin
        mode_q[s] <= in_mode[s];
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
      end
    end
  end

  // rounding: euclidean rounds up when remainder exceeds root,
  // att rounds up unless the root is exact
  logic                last_mode;
  logic [D2Bits-1:0]   last_rem;
  logic [RootBits-1:0] last_root;
  logic                bump;
  logic [RootBits:0]   fin;
  logic [DistBits-1:0] dist_d;

  assign last_mode = mode_q[RootBits-1];
  assign last_rem  = rem_q[RootBits-1];
  assign last_root = root_q[RootBits-1];

  always_comb begin
    if (last_mode == MODE_ATT) bump = (last_rem != '0);
    else                       bump = (last_rem > D2Bits'(last_root));
    fin = (RootBits+1)'(last_root) + (RootBits+1)'(bump);
    if (32'(fin) > 32'(DistMax)) dist_d = DistBits'(DistMax);
    else                         dist_d = DistBits'(fin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy[RootBits]) begin
      out_v_q <= v_q[RootBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[RootBits] && v_q[RootBits-1]) out_dist_q <= dist_d;
  end

  assign rsp_o.valid    = out_v_q;
  assign rsp_o.distance = out_dist_q;

endmodule

// ===== rtl/planar_city_distance_unit_core.sv =====
// path from input acceptance to a valid result when the queue is empty:
//   3 front stages, 1 queue write, 17 square root stages, 1 output register
// throughput: one transaction per cycle unless the receiver stalls (pipelined root)
// reset: asynchronous active low, empties every stage and the queue; no clearing pass
// depends on pcd_pkg, pcd_ifs, pcd_front, pcd_fifo, pcd_back
module planar_city_distance_unit_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcd_in_if.sink     req_i,
  pcd_out_if.source  rsp_o
);
  import pcd_pkg::*;

  // front to queue
  job_t fj;
  logic fj_valid, fj_ready;

  // queue to back
  job_t bj;
  logic bj_valid, bj_ready;

  // front: masks coordinates, forms absolute differences, squares and
  // their sum; a transaction is taken whenever its first stage can move
  pcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .job_o       (fj),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready)
  );

  // queue: absorbs short stalls so front and back stall independently
  pcd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (fj),
    .job_valid_i (fj_valid),
    .job_ready_o (fj_ready),
    .job_o       (bj),
    .job_valid_o (bj_valid),
    .job_ready_i (bj_ready)
  );

  // back: restoring square root, one root bit per stage; att mode scales
  // the subtrahend by ten so no divider is needed, then rounds and
  // holds the result in an output register that keeps the pipe moving
  pcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (bj),
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== rtl/pcd_checker.sv =====
// port-level checker for the distance unit, bound to the top level
// depends on pcd_pkg and assert_macros.svh
`include "assert_macros.svh"

module pcd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [pcd_pkg::DistBits-1:0] distance_i
);
  import pcd_pkg::*;

  // front stages, queue, root stages and output register
  localparam int MaxInFlight = 3 + QueueDepth + RootBits + 1;
  localparam int CntBits     = $clog2(MaxInFlight + 1) + 1;

  logic [CntBits-1:0] cnt_q;
  logic               in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  `PCD_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_i)
  `PCD_ASSERT(a_result_holds, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(distance_i))
  `PCD_ASSERT(a_no_invented_result, clk_i, rst_ni, out_valid_i |-> cnt_q != '0)
  `PCD_ASSERT(a_in_flight_bound, clk_i, rst_ni, cnt_q <= CntBits'(MaxInFlight))

endmodule

bind planar_city_distance_unit_core pcd_checker u_pcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .distance_i  (rsp_o.distance)
);

// ===== verif/pcd_distance_checker.sv =====
// watcher and scoreboard for the planar city distance unit
// predicts each distance from the request transactions and compares the responses in order
// depends on pcd_pkg and pcd_ifs
`timescale 1ns / 1ps

module pcd_distance_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pcd_in_if    req,
  pcd_out_if   rsp,
  output int   mismatches_o,
  output int   pending_o,
  output int   euc_checked_o,
  output int   att_checked_o
);
  import pcd_pkg::*;

  typedef struct {
    logic                mode;
    logic [InBits-1:0]   x_a;
    logic [InBits-1:0]   y_a;
    logic [InBits-1:0]   x_b;
    logic [InBits-1:0]   y_b;
    logic [DistBits-1:0] distance;
  } pair_distance_t;

  pair_distance_t pending_distances[$];
  int             fail_total;
  int             euc_total;
  int             att_total;

  // exact floor root, two bits of the radicand per step
  function automatic longint unsigned floor_root(input longint unsigned radicand);
    longint unsigned rest;
    longint unsigned root;
    longint unsigned trial;
    rest = radicand;
    root = 0;
    for (int k = 31; k >= 0; k--) begin
      trial = (root << (k + 1)) + (64'd1 << (2 * k));
      if (rest >= trial) begin
        rest = rest - trial;
        root = root | (64'd1 << k);
      end
    end
    return root;
  endfunction

  function automatic logic [DistBits-1:0] city_distance(
    input logic              mode,
    input logic [InBits-1:0] x_a,
    input logic [InBits-1:0] y_a,
    input logic [InBits-1:0] x_b,
    input logic [InBits-1:0] y_b
  );
    longint unsigned keep;
    longint unsigned xa, ya, xb, yb;
    longint unsigned dx, dy, d2, r, span;
    keep = (64'd1 << CoordBits) - 1;
    xa   = x_a & keep;
    ya   = y_a & keep;
    xb   = x_b & keep;
    yb   = y_b & keep;
    dx   = (xa >= xb) ? xa - xb : xb - xa;
    dy   = (ya >= yb) ? ya - yb : yb - ya;
    d2   = dx * dx + dy * dy;
    if (mode == MODE_EUC) begin
      r    = floor_root(d2);
      span = (d2 >= r * r + r + 1) ? r + 1 : r;
    end else begin
      r    = floor_root(d2 / 10);
      span = (10 * r * r == d2) ? r : r + 1;
    end
    if (span > DistMax) span = DistMax;
    return span[DistBits-1:0];
  endfunction

  task automatic flag_mismatch(input string what);
    fail_total++;
    if (fail_total <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin
    pair_distance_t oldest;
    pair_distance_t fresh;
    if (rst_ni) begin
      if (req.valid && req.ready) begin
        fresh.mode     = req.mode;
        fresh.x_a      = req.x_a;
        fresh.y_a      = req.y_a;
        fresh.x_b      = req.x_b;
        fresh.y_b      = req.y_b;
        fresh.distance = city_distance(req.mode, req.x_a, req.y_a, req.x_b, req.y_b);
        pending_distances = {pending_distances, fresh};
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_distances.size() == 0) begin
          flag_mismatch($sformatf("unexpected distance %0d", rsp.distance));
        end else begin
          oldest = pending_distances.pop_front();
          if (oldest.mode == MODE_EUC) euc_total++;
          else att_total++;
          if (rsp.distance !== oldest.distance) begin
            flag_mismatch($sformatf("mode %0d (%0d,%0d)-(%0d,%0d): expected %0d, got %0d",
              oldest.mode, oldest.x_a, oldest.y_a, oldest.x_b, oldest.y_b,
              oldest.distance, rsp.distance));
          end
        end
      end
    end
    mismatches_o  <= fail_total;
    pending_o     <= pending_distances.size();
    euc_checked_o <= euc_total;
    att_checked_o <= att_total;
  end

endmodule

// ===== verif/planar_city_distance_unit_core_tb.sv =====
// top of the planar city distance unit testbench: clock, reset, stimulus and verdict
// the checker beside the block does all prediction and comparison
// depends on pcd_pkg, pcd_ifs, pcd_distance_checker and the distance unit rtl
`timescale 1ns / 1ps

module planar_city_distance_unit_core_tb;
  import pcd_pkg::*;

  localparam int RandomPairs = 1500;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 40;   // more than the time a transaction spends in the unit when the queue is empty

  logic clk_i;
  logic rst_ni;

  pcd_in_if  req_if();
  pcd_out_if rsp_if();

  int mismatches;
  int pending;
  int euc_checked;
  int att_checked;

  // set by the stimulus to ask the receiver for one long hold-off
  bit hold_req;
  // set by the receiver once that hold-off is over
  bit hold_done;
  int sent_count;

  planar_city_distance_unit_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  pcd_distance_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req_if),
    .rsp           (rsp_if),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .euc_checked_o (euc_checked),
    .att_checked_o (att_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // present one city pair and hold it until the block takes it
  task automatic send_pair(input logic mode, input logic [InBits-1:0] xa,
                           input logic [InBits-1:0] ya, input logic [InBits-1:0] xb,
                           input logic [InBits-1:0] yb);
    @(negedge clk_i);
    req_if.valid = 1'b1;
    req_if.mode  = mode;
    req_if.x_a   = xa;
    req_if.y_a   = ya;
    req_if.x_b   = xb;
    req_if.y_b   = yb;
    do @(posedge clk_i); while (!req_if.ready);
    sent_count++;
  endtask

  // directed pairs go through both modes
  task automatic send_both_modes(input logic [InBits-1:0] xa, input logic [InBits-1:0] ya,
                                 input logic [InBits-1:0] xb, input logic [InBits-1:0] yb);
    send_pair(MODE_EUC, xa, ya, xb, yb);
    send_pair(MODE_ATT, xa, ya, xb, yb);
  endtask

  // one random pair from a mix of shapes
  task automatic send_random_pair();
    logic [InBits-1:0] xa, ya, xb, yb;
    int                shape;
    int                dx, dy, k;
    shape = $urandom_range(0, 9);
    xa    = InBits'($urandom);
    ya    = InBits'($urandom);
    xb    = InBits'($urandom);
    yb    = InBits'($urandom);
    case (shape)
      5, 6: begin
        // close neighbors, small distances where rounding matters most
        dx = $urandom_range(0, 15);
        dy = $urandom_range(0, 15);
        xb = InBits'((xa >= dx) ? xa - dx : xa + dx);
        yb = InBits'((ya >= dy) ? ya - dy : ya + dy);
      end
      7: begin
        // on one axis
        if ($urandom_range(0, 1)) xb = xa;
        else yb = ya;
      end
      8: begin
        // identical cities
        xb = xa;
        yb = ya;
      end
      9: begin
        // dx = 3k, dy = k gives a squared distance of exactly 10 k^2
        k  = $urandom_range(0, 21845);
        xa = InBits'($urandom_range(0, 65535 - 3 * k));
        ya = InBits'($urandom_range(0, 65535 - k));
        xb = InBits'(xa + 3 * k);
        yb = InBits'(ya + k);
        if ($urandom_range(0, 1)) begin
          {xa, xb} = {xb, xa};
        end
      end
      default: ;
    endcase
    send_pair(1'($urandom_range(0, 1)), xa, ya, xb, yb);
  endtask

  // receiver: ready changes at the falling edge, in styles that switch every so often
  initial begin
    int style;
    int style_left;
    int cyc;
    rsp_if.ready = 1'b0;
    style_left   = 0;
    cyc          = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_req && !hold_done) begin
        // long hold-off so the pipeline and queue fill and the input stalls
        rsp_if.ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(16, 128);
        end
        style_left--;
        case (style)
          0:       rsp_if.ready = 1'b1;
          1:       rsp_if.ready = 1'($urandom_range(0, 1));
          2:       rsp_if.ready = ($urandom_range(0, 3) == 0);
          default: rsp_if.ready = ((cyc % 8) < 5);
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin
    int burst_left;
    rst_ni       = 1'b0;
    hold_req     = 1'b0;
    sent_count   = 0;
    req_if.valid = 1'b0;
    req_if.mode  = MODE_EUC;
    req_if.x_a   = '0;
    req_if.y_a   = '0;
    req_if.x_b   = '0;
    req_if.y_b   = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: identical cities, the far corners, both diagonals and an axis,
    // a 3-4-5 triangle, squared distances that are exact multiples of ten,
    // and the smallest nonzero distances
    send_both_modes(16'd0, 16'd0, 16'd0, 16'd0);
    send_both_modes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_both_modes(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    send_both_modes(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    send_both_modes(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    send_both_modes(16'd0, 16'd0, 16'hFFFF, 16'd0);
    send_both_modes(16'd0, 16'd0, 16'd3, 16'd4);
    send_both_modes(16'd0, 16'd0, 16'd3, 16'd1);
    send_both_modes(16'd100, 16'd50, 16'd70, 16'd40);
    send_both_modes(16'd7, 16'd7, 16'd8, 16'd8);
    send_both_modes(16'd0, 16'd1, 16'hFFFF, 16'd0);

    // random content with the receiver held off for a while at the start
    hold_req   = 1'b1;
    burst_left = 60;
    for (int i = 0; i < RandomPairs; i++) begin
      if (burst_left == 0) begin
        // sender gap, then a fresh burst
        @(negedge clk_i);
        req_if.valid = 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
        burst_left = $urandom_range(1, 40);
      end
      send_random_pair();
      burst_left--;
    end
    @(negedge clk_i);
    req_if.valid = 1'b0;

    // drain every outstanding distance, then let the pipeline settle
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d city pairs; checked %0d rounded euclidean and %0d att distances",
             sent_count, euc_checked, att_checked);
    $display("included a %0d cycle receiver hold-off and randomized sender gaps", HoldCycles);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
